@@ hdl/pdks_pkg.sv @@
`default_nettype none
package pdks_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  localparam int MAX_RES = 3;
  localparam int CNT_W   = 2;
  localparam int IDX_W   = 2;

  typedef enum logic [1:0] {
    PH_PLAIN = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DROP  = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       bad_encoding;
    logic       path_end;
    logic       run_last;
  } res_t;

  // everything one input item produces, handed to the output buffer
  typedef struct packed {
    logic [CNT_W-1:0] count;
    res_t             res2;
    res_t             res1;
    res_t             res0;
  } dec_out_t;

  function automatic logic hex_ok(input logic [7:0] c);
    logic ok;
    case (c) inside
      [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    case (c) inside
      [8'h30:8'h39]: v = c - 8'h30;
      [8'h41:8'h46]: v = c - 8'h37;
      [8'h61:8'h66]: v = c - 8'h57;
      default:       v = 8'h00;
    endcase
    return v[3:0];
  endfunction

endpackage
`default_nettype wire

@@ hdl/pdks_decode.sv @@
`default_nettype none
module pdks_decode (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [7:0]        char_in,
  input  wire logic              is_last,
  input  wire logic              adv,
  output pdks_pkg::dec_out_t     dec
);

  pdks_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [7:0]       v;
  pdks_pkg::res_t   fail_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pdks_pkg::PH_PLAIN;
      held_r  <= 8'h00;
    end else if (adv) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

  assign fail_res = '{out_byte: 8'h00, bad_encoding: 1'b1, path_end: 1'b1, run_last: 1'b1};
  assign v = {pdks_pkg::hex_val(held_r), pdks_pkg::hex_val(char_in)};

  always_comb begin
    phase_nxt = phase_r;
    held_nxt  = held_r;
    dec       = '0;
    case (phase_r)
      pdks_pkg::PH_PLAIN: begin
        if (char_in != pdks_pkg::CH_PCT) begin
          dec.count = 2'd1;
          dec.res0  = '{out_byte: char_in, bad_encoding: 1'b0, path_end: is_last,
                        run_last: 1'b1};
        end else if (is_last) begin
          dec.count = 2'd1;
          dec.res0  = fail_res;
        end else begin
          phase_nxt = pdks_pkg::PH_PCT;
        end
      end
      pdks_pkg::PH_PCT: begin
        if (!pdks_pkg::hex_ok(char_in) || is_last) begin
          dec.count = 2'd1;
          dec.res0  = fail_res;
          phase_nxt = is_last ? pdks_pkg::PH_PLAIN : pdks_pkg::PH_DROP;
        end else begin
          held_nxt  = char_in;
          phase_nxt = pdks_pkg::PH_DIGIT;
        end
      end
      pdks_pkg::PH_DIGIT: begin
        if (!pdks_pkg::hex_ok(held_r) || !pdks_pkg::hex_ok(char_in)) begin
          dec.count = 2'd1;
          dec.res0  = fail_res;
          phase_nxt = is_last ? pdks_pkg::PH_PLAIN : pdks_pkg::PH_DROP;
        end else begin
          phase_nxt = pdks_pkg::PH_PLAIN;
          if (v != pdks_pkg::CH_SLASH && v != pdks_pkg::CH_BSL) begin
            dec.count = 2'd1;
            dec.res0  = '{out_byte: v, bad_encoding: 1'b0, path_end: is_last,
                          run_last: 1'b1};
          end else begin
            // encoded slash or backslash stays encoded: replay the three source characters
            dec.count = 2'd3;
            dec.res0  = '{out_byte: pdks_pkg::CH_PCT, bad_encoding: 1'b0,
                          path_end: 1'b0, run_last: 1'b0};
            dec.res1  = '{out_byte: held_r, bad_encoding: 1'b0, path_end: 1'b0,
                          run_last: 1'b0};
            dec.res2  = '{out_byte: char_in, bad_encoding: 1'b0, path_end: is_last,
                          run_last: 1'b1};
          end
        end
      end
      default: begin
        if (is_last) phase_nxt = pdks_pkg::PH_PLAIN;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/pdks_out_buf.sv @@
`default_nettype none
module pdks_out_buf (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           load,
  input  wire pdks_pkg::dec_out_t             dec,
  input  wire logic                           pop,
  output logic [pdks_pkg::CNT_W-1:0]          rem,
  output pdks_pkg::res_t                      head
);

  pdks_pkg::res_t                 ent_r [pdks_pkg::MAX_RES];
  logic [pdks_pkg::CNT_W-1:0]     rem_r;
  logic [pdks_pkg::IDX_W-1:0]     head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      head_r <= '0;
    end else if (load) begin
      rem_r  <= dec.count;
      head_r <= '0;
    end else if (pop) begin
      rem_r  <= rem_r - 2'd1;
      head_r <= head_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r[0] <= dec.res0;
      ent_r[1] <= dec.res1;
      ent_r[2] <= dec.res2;
    end
  end

  always_comb begin
    case (head_r)
      2'd0:    head = ent_r[0];
      2'd1:    head = ent_r[1];
      default: head = ent_r[2];
    endcase
  end

  assign rem = rem_r;

endmodule
`default_nettype wire

@@ hdl/percent_decode_keep_slashes_top.sv @@
// channel | direction | ports
// input   | in        | in_valid, in_stall, in_char_in, in_is_last
// result  | out       | out_valid, out_stall, out_byte, out_bad_encoding, out_path_end,
//         |           | out_run_last
//
// one input transaction per cycle sustained while the result buffer has room;
// the first result appears after the input register, then the result buffer
// a kept slash yields three results, read out one per cycle from the result buffer while
// out_stall is low, so a following input that yields results stalls behind it
// synchronous active-low reset clears the decode phase and empties both stages
// out_stall holds the head result; the input register still fills behind it
`default_nettype none
module percent_decode_keep_slashes_top (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_in,
  input  wire logic       in_is_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_bad_encoding,
  output logic            out_path_end,
  output logic            out_run_last
);

  logic                          v1_r;
  logic [7:0]                    char_r;
  logic                          last_r;
  logic                          adv, pop, buf_free, load;
  logic [pdks_pkg::CNT_W-1:0]    rem;
  pdks_pkg::dec_out_t            dec;
  pdks_pkg::res_t                head;

  assign out_valid = (rem != '0);
  assign pop       = out_valid && !out_stall;
  assign buf_free  = (rem == '0) || (rem == 2'd1 && pop);
  // items that produce nothing only move the phase and need no buffer space
  assign adv       = v1_r && (buf_free || dec.count == '0);
  assign load      = adv && (dec.count != '0);
  assign in_stall  = v1_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (!in_stall) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      char_r <= in_char_in;
      last_r <= in_is_last;
    end
  end

  pdks_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .char_in (char_r),
    .is_last (last_r),
    .adv     (adv),
    .dec     (dec)
  );

  pdks_out_buf u_out_buf (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .dec   (dec),
    .pop   (pop),
    .rem   (rem),
    .head  (head)
  );

  assign out_byte         = head.out_byte;
  assign out_bad_encoding = head.bad_encoding;
  assign out_path_end     = head.path_end;
  assign out_run_last     = head.run_last;

  // a result that is not the last of its run is always followed by another
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_run_last) |=> out_valid)
    else $error("result run broken before run_last");

  a_bad_ends_path: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_encoding) |-> (out_path_end && out_run_last && out_byte == 8'h00))
    else $error("error result without path end");

  a_stall_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && out_valid))
    else $error("input stalled with nothing pending");

endmodule
`default_nettype wire
